// File: rtl/psw_pkg.sv
// Package for the plucked string wave model: widths, codes, fixed-point constants
// and the rounding and saturation helpers used by the datapath.
// No dependencies.
package psw_pkg;

   localparam int NODE_MAX = 256;
   localparam int IDX_W    = $clog2(NODE_MAX);
   localparam int CNT_W    = 9;
   localparam int DISP_W   = 24;
   localparam int POS_W    = 17;
   localparam int DAMP_W   = 16;
   localparam int WSS_W    = 17;
   localparam int CSR_W    = 17;
   localparam int FRAC_W   = 16;
   localparam int MUL_W    = 27;
   localparam int PROD_W   = 2 * MUL_W;

   localparam int LOSS_Q24  = 16777;
   localparam int SMOOTH_K  = 2 * ((1 << 24) - LOSS_Q24);
   localparam int POS_ONE   = 65536;

   localparam logic signed [PROD_W-1:0] DISP_MAX = PROD_W'(8388607);
   localparam logic signed [PROD_W-1:0] DISP_MIN = -PROD_W'(8388608);

   typedef enum logic [1:0] {
      OP_PLUCK  = 2'd0,
      OP_STEP   = 2'd1,
      OP_SAMPLE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_NODE_COUNT = 2'd0,
      CSR_DAMPING    = 2'd1,
      CSR_WAVE_SPEED = 2'd2
   } csr_type;

   // divide by 2^sh, round half away from zero
   function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] x,
      input int unsigned              sh
   );
      logic             neg;
      logic [PROD_W-1:0] m;
      neg = x[PROD_W-1];
      m   = neg ? PROD_W'(-x) : PROD_W'(x);
      m   = (m + (PROD_W'(1) << (sh - 1))) >> sh;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [DISP_W-1:0] sat_disp(input logic signed [PROD_W-1:0] x);
      logic signed [DISP_W-1:0] r;
      if (x > DISP_MAX) begin
         r = DISP_MAX[DISP_W-1:0];
      end else if (x < DISP_MIN) begin
         r = DISP_MIN[DISP_W-1:0];
      end else begin
         r = x[DISP_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/psw_req_if.sv
// Request channel of the plucked string wave model: valid/ready plus payload.
// Depends on psw_pkg for field widths.
interface psw_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            operation;
   logic [psw_pkg::POS_W-1:0]             position;
   logic signed [psw_pkg::DISP_W-1:0]     amplitude;

   modport source (output valid, operation, position, amplitude, input ready);
   modport sink   (input valid, operation, position, amplitude, output ready);
endinterface

// File: rtl/psw_rsp_if.sv
// Response channel of the plucked string wave model: valid/ready plus sample.
// Depends on psw_pkg for field widths.
interface psw_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [psw_pkg::DISP_W-1:0]     sample_value;

   modport source (output valid, sample_value, input ready);
   modport sink   (input valid, sample_value, output ready);
endinterface

// File: rtl/psw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psw_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/plucked_string_wave_model.sv
// Plucked string wave model, top level.
// Depends on psw_pkg, psw_req_if, psw_rsp_if and psw_ram.
//
// Usage: a request beat carries operation, position and amplitude. Pluck loads a
// triangle shape into the current displacement and clears the previous one; step
// runs the damped wave update plus the left-to-right loss smoothing; sample
// returns one interpolated displacement on the response channel. Pluck and step
// return nothing. csr_wr_en/csr_index/csr_wr_data write node_count, damping and
// wave_speed_squared; write them only while the block is idle.
// Flow: one request at a time, req ready only while idle. A pluck runs two
// serial divides plus one RAM write per node in use; a step uses one shared
// multiplier four times per node, one node at a time.
// Reset: synchronous; afterwards both displacement RAMs are swept to zero, all
// 256 addresses, while req ready stays low.
// A stalled response holds in its output register; the block still takes the
// next request and only waits if another sample result is ready before the
// previous one has been taken.
module plucked_string_wave_model (
   input  logic                      clock,
   input  logic                      reset,
   psw_req_if.sink                   req_ch,
   psw_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [psw_pkg::CSR_W-1:0] csr_wr_data
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_PK_T, ST_PK_PEAK, ST_PK_DIV, ST_PK_RUN,
      ST_ST_INIT0, ST_ST_INIT1, ST_ST_INIT2,
      ST_RD, ST_LAP, ST_MW, ST_MD, ST_MR, ST_S1, ST_S2, ST_S3, ST_T4,
      ST_SM_T, ST_SM_RD0, ST_SM_RD1, ST_SM_M0, ST_SM_M1, ST_SM_FIN, ST_OUT
   } state_type;

   localparam int IW = psw_pkg::IDX_W;
   localparam int DW = psw_pkg::DISP_W;
   localparam int MW = psw_pkg::MUL_W;
   localparam int PW = psw_pkg::PROD_W;

   state_type state_ff;

   logic [psw_pkg::CNT_W-1:0]  node_count_ff;
   logic [psw_pkg::DAMP_W-1:0] damping_ff;
   logic [psw_pkg::WSS_W-1:0]  wss_ff;

   logic [IW-1:0]       idx_ff, lim_ff;
   logic signed [DW-1:0] cm1_ff, c0_ff, cp1_ff, p0_ff;
   logic signed [DW+1:0] lap_ff;
   logic signed [DW:0]   dcp_ff;
   logic signed [PW-1:0] acc_ff, prod_ff;
   logic signed [DW-1:0] rawm1_ff, nb_ff, um_ff, res_ff;
   logic                tail_ff;

   logic [psw_pkg::POS_W-1:0] pos_ff;
   logic [DW-1:0]             mag_ff;
   logic                      neg_ff;
   logic [IW-1:0]             peak_ff, den_ff;
   logic                      side_ff;
   logic [DW-1:0]             div_q_ff, q_run_ff;
   logic [IW-1:0]             div_r_ff, r_run_ff;
   logic [4:0]                div_cnt_ff;

   logic [psw_pkg::FRAC_W-1:0] frac_ff;

   logic                      rsp_valid_ff;
   logic signed [DW-1:0]      rsp_data_ff;

   // node count in use and derived limits
   logic [psw_pkg::CNT_W-1:0] n_used;
   logic [IW-1:0]             nm1, nm2;

   always_comb begin
      if (node_count_ff < psw_pkg::CNT_W'(4)) begin
         n_used = psw_pkg::CNT_W'(4);
      end else if (node_count_ff > psw_pkg::CNT_W'(psw_pkg::NODE_MAX)) begin
         n_used = psw_pkg::CNT_W'(psw_pkg::NODE_MAX);
      end else begin
         n_used = node_count_ff;
      end
      nm1 = IW'(n_used - psw_pkg::CNT_W'(1));
      nm2 = IW'(n_used - psw_pkg::CNT_W'(2));
   end

   // RAMs
   logic              cur_we, prev_we;
   logic [IW-1:0]     cur_wa, prev_wa, cur_ra, prev_ra;
   logic [DW-1:0]     cur_wd, prev_wd, cur_rd_raw, prev_rd_raw;
   logic signed [DW-1:0] cur_rd, prev_rd;

   assign cur_rd  = cur_rd_raw;
   assign prev_rd = prev_rd_raw;

   psw_ram #(.WIDTH(DW), .DEPTH(psw_pkg::NODE_MAX)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_wa),
      .wr_data (cur_wd),
      .rd_addr (cur_ra),
      .rd_data (cur_rd_raw)
   );

   psw_ram #(.WIDTH(DW), .DEPTH(psw_pkg::NODE_MAX)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (prev_ra),
      .rd_data (prev_rd_raw)
   );

   // sample index decode straight off the product register
   logic [psw_pkg::CNT_W-1:0] t_hi;
   logic                      sm_clamp;
   assign t_hi     = prod_ff[24:16];
   assign sm_clamp = t_hi >= {1'b0, nm1};

   // pluck peak, held to 1..N-2
   logic [IW-1:0] peak_c;
   always_comb begin
      if (t_hi < psw_pkg::CNT_W'(1)) begin
         peak_c = IW'(1);
      end else if (t_hi > {1'b0, nm2}) begin
         peak_c = nm2;
      end else begin
         peak_c = t_hi[IW-1:0];
      end
   end

   // serial divider step
   logic [IW:0]   div_rem2;
   logic          div_fit;
   logic [IW-1:0] div_rem_next;
   assign div_rem2     = {div_r_ff, div_q_ff[DW-1]};
   assign div_fit      = div_rem2 >= {1'b0, den_ff};
   assign div_rem_next = div_fit ? IW'(div_rem2 - {1'b0, den_ff}) : div_rem2[IW-1:0];

   // running quotient for the triangle ramp
   logic [IW:0]          run_sum;
   logic                 run_wrap;
   logic [IW-1:0]        pk_addr;
   logic signed [DW-1:0] pk_val;
   assign run_sum  = {1'b0, r_run_ff} + {1'b0, div_r_ff};
   assign run_wrap = run_sum >= {1'b0, den_ff};
   assign pk_addr  = side_ff ? IW'(nm1 - idx_ff) : idx_ff;
   assign pk_val   = neg_ff ? -$signed(q_run_ff) : $signed(q_run_ff);

   // datapath results
   logic signed [DW-1:0] raw_c, smooth_c;
   assign raw_c    = psw_pkg::sat_disp(acc_ff - psw_pkg::round_shift(prod_ff, 16));
   assign smooth_c = psw_pkg::sat_disp(psw_pkg::round_shift(acc_ff + prod_ff, 25));

   // shared multiplier operands
   logic signed [MW-1:0] mul_a, mul_b;

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      cur_we  = 1'b0;
      cur_wa  = idx_ff;
      cur_wd  = '0;
      cur_ra  = idx_ff;
      prev_we = 1'b0;
      prev_wa = idx_ff;
      prev_wd = '0;
      prev_ra = idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cur_we  = 1'b1;
            prev_we = 1'b1;
         end
         ST_PK_T, ST_SM_T: begin
            mul_a = {10'b0, pos_ff};
            mul_b = {{(MW-IW){1'b0}}, nm1};
         end
         ST_PK_RUN: begin
            cur_we  = 1'b1;
            cur_wa  = pk_addr;
            cur_wd  = pk_val;
            prev_we = 1'b1;
            prev_wa = pk_addr;
         end
         ST_ST_INIT0: begin
            cur_ra = '0;
         end
         ST_ST_INIT1: begin
            cur_we  = 1'b1;
            cur_wa  = '0;
            prev_we = 1'b1;
            prev_wa = '0;
            prev_wd = cur_rd;
            cur_ra  = IW'(1);
         end
         ST_RD: begin
            cur_ra  = IW'(idx_ff + 1'b1);
            prev_ra = idx_ff;
         end
         ST_MW: begin
            mul_a = {10'b0, wss_ff};
            mul_b = MW'(lap_ff);
         end
         ST_MD: begin
            mul_a = {11'b0, damping_ff};
            mul_b = MW'(dcp_ff);
         end
         ST_S1: begin
            mul_a = MW'(rawm1_ff);
            mul_b = MW'(psw_pkg::SMOOTH_K);
         end
         ST_S2: begin
            mul_a = MW'(psw_pkg::LOSS_Q24);
            mul_b = MW'(um_ff) + MW'(nb_ff);
         end
         ST_S3: begin
            cur_we  = 1'b1;
            cur_wa  = IW'(idx_ff - 1'b1);
            cur_wd  = smooth_c;
            prev_we = 1'b1;
            prev_wa = IW'(idx_ff - 1'b1);
            prev_wd = cm1_ff;
         end
         ST_T4: begin
            cur_we  = 1'b1;
            prev_we = 1'b1;
            prev_wd = c0_ff;
         end
         ST_SM_RD0: begin
            cur_ra = sm_clamp ? nm1 : t_hi[IW-1:0];
         end
         ST_SM_RD1: begin
            cur_ra = IW'(idx_ff + 1'b1);
         end
         ST_SM_M0: begin
            mul_a = MW'(cm1_ff);
            mul_b = {10'b0, 17'(17'(psw_pkg::POS_ONE) - {1'b0, frac_ff})};
         end
         ST_SM_M1: begin
            mul_a = MW'(cp1_ff);
            mul_b = {11'b0, frac_ff};
         end
         default: begin
         end
      endcase
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sample_value = rsp_data_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end

      if (csr_wr_en) begin
         priority case (csr_index)
            psw_pkg::CSR_NODE_COUNT: node_count_ff <= csr_wr_data[psw_pkg::CNT_W-1:0];
            psw_pkg::CSR_DAMPING:    damping_ff    <= csr_wr_data[psw_pkg::DAMP_W-1:0];
            psw_pkg::CSR_WAVE_SPEED: wss_ff        <= csr_wr_data[psw_pkg::WSS_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            idx_ff <= IW'(idx_ff + 1'b1);
            if (idx_ff == IW'(psw_pkg::NODE_MAX - 1)) begin
               state_ff <= ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               pos_ff <= (req_ch.position > psw_pkg::POS_W'(psw_pkg::POS_ONE)) ?
                         psw_pkg::POS_W'(psw_pkg::POS_ONE) : req_ch.position;
               neg_ff <= req_ch.amplitude[DW-1];
               mag_ff <= req_ch.amplitude[DW-1] ? DW'(-req_ch.amplitude) :
                         DW'(req_ch.amplitude);
               unique case (req_ch.operation)
                  psw_pkg::OP_PLUCK:  state_ff <= ST_PK_T;
                  psw_pkg::OP_STEP:   state_ff <= ST_ST_INIT0;
                  psw_pkg::OP_SAMPLE: state_ff <= ST_SM_T;
                  default:            state_ff <= ST_IDLE;
               endcase
            end
         end

         // pluck
         ST_PK_T: begin
            state_ff <= ST_PK_PEAK;
         end
         ST_PK_PEAK: begin
            peak_ff    <= peak_c;
            den_ff     <= peak_c;
            lim_ff     <= peak_c;
            side_ff    <= 1'b0;
            div_q_ff   <= mag_ff;
            div_r_ff   <= '0;
            div_cnt_ff <= '0;
            q_run_ff   <= '0;
            r_run_ff   <= '0;
            idx_ff     <= '0;
            state_ff   <= ST_PK_DIV;
         end
         ST_PK_DIV: begin
            div_q_ff   <= {div_q_ff[DW-2:0], div_fit};
            div_r_ff   <= div_rem_next;
            div_cnt_ff <= 5'(div_cnt_ff + 1'b1);
            if (div_cnt_ff == 5'(DW - 1)) begin
               state_ff <= ST_PK_RUN;
            end
         end
         ST_PK_RUN: begin
            if (run_wrap) begin
               r_run_ff <= IW'(run_sum - {1'b0, den_ff});
               q_run_ff <= DW'(q_run_ff + div_q_ff + 1'b1);
            end else begin
               r_run_ff <= run_sum[IW-1:0];
               q_run_ff <= DW'(q_run_ff + div_q_ff);
            end
            idx_ff <= IW'(idx_ff + 1'b1);
            if (idx_ff == lim_ff) begin
               if (!side_ff) begin
                  // right flank, walked from the far end inward
                  side_ff    <= 1'b1;
                  den_ff     <= IW'(nm1 - peak_ff);
                  lim_ff     <= IW'(nm1 - peak_ff - 1'b1);
                  div_q_ff   <= mag_ff;
                  div_r_ff   <= '0;
                  div_cnt_ff <= '0;
                  q_run_ff   <= '0;
                  r_run_ff   <= '0;
                  idx_ff     <= '0;
                  state_ff   <= ST_PK_DIV;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
         end

         // step
         ST_ST_INIT0: begin
            state_ff <= ST_ST_INIT1;
         end
         ST_ST_INIT1: begin
            cm1_ff   <= cur_rd;
            state_ff <= ST_ST_INIT2;
         end
         ST_ST_INIT2: begin
            c0_ff    <= cur_rd;
            um_ff    <= '0;
            tail_ff  <= 1'b0;
            idx_ff   <= IW'(1);
            state_ff <= ST_RD;
         end
         ST_RD: begin
            state_ff <= ST_LAP;
         end
         ST_LAP: begin
            cp1_ff   <= cur_rd;
            p0_ff    <= prev_rd;
            lap_ff   <= (DW+2)'(cur_rd) - ((DW+2)'(c0_ff) <<< 1) + (DW+2)'(cm1_ff);
            dcp_ff   <= (DW+1)'(c0_ff) - (DW+1)'(prev_rd);
            state_ff <= ST_MW;
         end
         ST_MW: begin
            state_ff <= ST_MD;
         end
         ST_MD: begin
            acc_ff   <= (PW'(c0_ff) <<< 1) - PW'(p0_ff) + psw_pkg::round_shift(prod_ff, 16);
            state_ff <= ST_MR;
         end
         ST_MR: begin
            if (idx_ff == IW'(1)) begin
               rawm1_ff <= raw_c;
               cm1_ff   <= c0_ff;
               c0_ff    <= cp1_ff;
               idx_ff   <= IW'(2);
               state_ff <= ST_RD;
            end else begin
               nb_ff    <= raw_c;
               state_ff <= ST_S1;
            end
         end
         ST_S1: begin
            state_ff <= ST_S2;
         end
         ST_S2: begin
            acc_ff   <= prod_ff;
            state_ff <= ST_S3;
         end
         ST_S3: begin
            um_ff <= smooth_c;
            if (tail_ff) begin
               state_ff <= ST_T4;
            end else begin
               cm1_ff   <= c0_ff;
               c0_ff    <= cp1_ff;
               rawm1_ff <= nb_ff;
               idx_ff   <= IW'(idx_ff + 1'b1);
               if (idx_ff == nm2) begin
                  // last inner node still needs smoothing, right end reads as zero
                  tail_ff  <= 1'b1;
                  nb_ff    <= '0;
                  state_ff <= ST_S1;
               end else begin
                  state_ff <= ST_RD;
               end
            end
         end
         ST_T4: begin
            tail_ff  <= 1'b0;
            state_ff <= ST_IDLE;
         end

         // sample
         ST_SM_T: begin
            state_ff <= ST_SM_RD0;
         end
         ST_SM_RD0: begin
            frac_ff  <= prod_ff[psw_pkg::FRAC_W-1:0];
            idx_ff   <= sm_clamp ? nm1 : t_hi[IW-1:0];
            tail_ff  <= sm_clamp;
            state_ff <= ST_SM_RD1;
         end
         ST_SM_RD1: begin
            if (tail_ff) begin
               res_ff   <= cur_rd;
               tail_ff  <= 1'b0;
               state_ff <= ST_OUT;
            end else begin
               cm1_ff   <= cur_rd;
               state_ff <= ST_SM_M0;
            end
         end
         ST_SM_M0: begin
            cp1_ff   <= cur_rd;
            state_ff <= ST_SM_M1;
         end
         ST_SM_M1: begin
            acc_ff   <= prod_ff;
            state_ff <= ST_SM_FIN;
         end
         ST_SM_FIN: begin
            res_ff   <= psw_pkg::sat_disp(psw_pkg::round_shift(acc_ff + prod_ff, 16));
            state_ff <= ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= res_ff;
               state_ff     <= ST_IDLE;
            end
         end
         default: begin
            state_ff <= ST_IDLE;
         end
      endcase

      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         tail_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= psw_pkg::CNT_W'(psw_pkg::NODE_MAX);
         damping_ff    <= '0;
         wss_ff        <= psw_pkg::WSS_W'(psw_pkg::POS_ONE);
      end
   end

endmodule

// File: test/tb_plucked_string_wave_model.sv
// Testbench for plucked_string_wave_model: random and directed pluck/step/sample beats,
// with an in-bench string predictor and a check of every pickup value.
// Depends on psw_pkg, psw_req_if, psw_rsp_if and the block's RTL.
`timescale 1ns / 100ps

class pickup_tracker;
   localparam int NODES = psw_pkg::NODE_MAX;
   localparam longint LOSS = 16777;

   logic signed [23:0] disp_now [NODES];
   logic signed [23:0] disp_old [NODES];
   int unsigned node_count = 256;
   int unsigned damping = 0;
   int unsigned wave_speed_sq = 65536;
   logic signed [23:0] pickup_due [$];
   int errors = 0;
   int plucks = 0;
   int steps = 0;
   int pickups = 0;

   function new();
      foreach (disp_now[i]) begin
         disp_now[i] = '0;
         disp_old[i] = '0;
      end
   endfunction

   function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endfunction

   function void set_reg(int unsigned idx, int unsigned data);
      case (idx)
         psw_pkg::CSR_NODE_COUNT: node_count = data & 'h1ff;
         psw_pkg::CSR_DAMPING:    damping = data & 'hffff;
         psw_pkg::CSR_WAVE_SPEED: wave_speed_sq = data & 'h1ffff;
         default: ;
      endcase
   endfunction

   function int nodes_used();
      if (node_count < 4) return 4;
      if (node_count > NODES) return NODES;
      return node_count;
   endfunction

   // divide by 2^sh, half away from zero
   function longint rnd(longint x, int sh);
      longint m;
      m = (x < 0) ? -x : x;
      m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
      return (x < 0) ? -m : m;
   endfunction

   function logic signed [23:0] sat(longint x);
      if (x > 8388607) return 24'sh7fffff;
      if (x < -8388608) return 24'sh800000;
      return x[23:0];
   endfunction

   function void apply_pluck(longint pos, longint amp);
      int n;
      longint peak;
      longint v;
      n = nodes_used();
      peak = (pos * (n - 1)) >>> 16;
      if (peak < 1) peak = 1;
      if (peak > n - 2) peak = n - 2;
      for (int i = 0; i < n; i++) begin
         if (i <= peak) v = (amp * i) / peak;
         else v = (amp * (n - 1 - i)) / (n - 1 - peak);
         disp_now[i] = sat(v);
         disp_old[i] = '0;
      end
      disp_now[0] = '0;
      disp_now[n-1] = '0;
   endfunction

   function void apply_step();
      int n;
      longint c, p, lap, acc;
      logic signed [23:0] nxt [NODES];
      n = nodes_used();
      nxt[0] = '0;
      nxt[n-1] = '0;
      for (int i = 1; i < n - 1; i++) begin
         c = disp_now[i];
         p = disp_old[i];
         lap = longint'(disp_now[i+1]) - 2 * c + longint'(disp_now[i-1]);
         nxt[i] = sat(2 * c - p + rnd(longint'(wave_speed_sq) * lap, 16)
                      - rnd(longint'(damping) * (c - p), 16));
      end
      // smoothing sees the already updated left neighbor
      for (int i = 1; i < n - 1; i++) begin
         acc = 2 * longint'(nxt[i]) * ((longint'(1) << 24) - LOSS)
               + LOSS * (longint'(nxt[i-1]) + longint'(nxt[i+1]));
         nxt[i] = sat(rnd(acc, 25));
      end
      for (int i = 0; i < n; i++) begin
         disp_old[i] = disp_now[i];
         disp_now[i] = nxt[i];
      end
   endfunction

   function logic signed [23:0] pickup_value(longint pos);
      int n;
      longint t, idx, f;
      n = nodes_used();
      t = pos * (n - 1);
      idx = t >>> 16;
      f = t & 65535;
      if (idx >= n - 1) return disp_now[n-1];
      return sat(rnd(longint'(disp_now[idx]) * (65536 - f)
                     + longint'(disp_now[idx+1]) * f, 16));
   endfunction

   function void note_request(logic [1:0] op, logic [16:0] position, logic signed [23:0] amp);
      longint pos;
      pos = (position > 65536) ? 65536 : position;
      case (op)
         psw_pkg::OP_PLUCK: begin
            apply_pluck(pos, amp);
            plucks++;
         end
         psw_pkg::OP_STEP: begin
            apply_step();
            steps++;
         end
         psw_pkg::OP_SAMPLE: pickup_due.push_back(pickup_value(pos));
         default: ;
      endcase
   endfunction

   function void check_pickup(logic signed [23:0] got);
      logic signed [23:0] want;
      if (pickup_due.size() == 0) begin
         report($sformatf("unexpected sample_value %0d", got));
         return;
      end
      want = pickup_due.pop_front();
      pickups++;
      if (got !== want) report($sformatf("sample_value %0d, want %0d", got, want));
   endfunction
endclass

module tb_plucked_string_wave_model;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE = 2500;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [psw_pkg::CSR_W-1:0] csr_wr_data;
   bit calm = 1'b0;
   int idle_cycles = 0;

   psw_req_if req_ch ();
   psw_rsp_if rsp_ch ();

   pickup_tracker book = new();

   plucked_string_wave_model dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = '0;
      req_ch.position = '0;
      req_ch.amplitude = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) rsp_ch.ready <= calm || ($urandom_range(99) >= 20);
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) book.check_pickup(rsp_ch.sample_value);
         if (req_ch.valid && req_ch.ready)
            book.note_request(req_ch.operation, req_ch.position, req_ch.amplitude);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task send_beat(logic [1:0] op, logic [16:0] pos, logic [23:0] amp);
      while (!calm && $urandom_range(99) < 20) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.position <= pos;
      req_ch.amplitude <= amp;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task send_random();
      logic [1:0] op;
      logic [16:0] pos;
      logic [23:0] amp;
      int r;
      r = $urandom_range(99);
      op = (r < 8) ? psw_pkg::OP_PLUCK : (r < 48) ? psw_pkg::OP_STEP :
           (r < 95) ? psw_pkg::OP_SAMPLE : OP_UNUSED;
      case ($urandom_range(9))
         0: pos = 17'd0;
         1: pos = 17'd65536;
         2: pos = 17'($urandom_range(131071, 65537));
         default: pos = 17'($urandom_range(65536));
      endcase
      case ($urandom_range(9))
         0: amp = 24'h7fffff;
         1: amp = 24'h800000;
         default: amp = 24'($urandom());
      endcase
      send_beat(op, pos, amp);
   endtask

   // drain all pickups, then let a long step finish before touching registers
   task drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (book.pickup_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_reg(logic [1:0] idx, int unsigned data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= psw_pkg::CSR_W'(data);
      @(posedge clock);
      book.set_reg(32'(idx), data);
   endtask

   task setup(int unsigned n, int unsigned damp, int unsigned wss);
      write_reg(psw_pkg::CSR_NODE_COUNT, n);
      write_reg(psw_pkg::CSR_DAMPING, damp);
      write_reg(psw_pkg::CSR_WAVE_SPEED, wss);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty string, extremes of position and amplitude, unused code
      send_beat(psw_pkg::OP_SAMPLE, 17'd32768, 24'h0);
      send_beat(psw_pkg::OP_PLUCK, 17'd0, 24'h7fffff);
      send_beat(psw_pkg::OP_SAMPLE, 17'd0, 24'h0);
      send_beat(psw_pkg::OP_SAMPLE, 17'd257, 24'h0);
      send_beat(psw_pkg::OP_SAMPLE, 17'd65536, 24'h0);
      send_beat(psw_pkg::OP_STEP, 17'd0, 24'h0);
      send_beat(psw_pkg::OP_SAMPLE, 17'd255, 24'h0);
      send_beat(psw_pkg::OP_PLUCK, 17'd131071, 24'h800000);
      send_beat(psw_pkg::OP_SAMPLE, 17'd65280, 24'h0);
      send_beat(psw_pkg::OP_SAMPLE, 17'd131071, 24'h0);
      send_beat(OP_UNUSED, 17'd40000, 24'h123456);
      send_beat(psw_pkg::OP_STEP, 17'd1, 24'hffffff);
      send_beat(psw_pkg::OP_SAMPLE, 17'd65000, 24'h0);
      send_beat(psw_pkg::OP_PLUCK, 17'd32768, 24'hffffff);
      send_beat(psw_pkg::OP_STEP, 17'd0, 24'h0);
      send_beat(psw_pkg::OP_STEP, 17'd0, 24'h0);
      send_beat(psw_pkg::OP_SAMPLE, 17'd32768, 24'h0);
      send_beat(psw_pkg::OP_SAMPLE, 17'd100, 24'h0);

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         count = 240;
         calm = 1'b0;
         case (phase)
            0: setup(16, 0, 65536);
            1: setup(4, 65535, 0);
            2: setup($urandom_range(64, 5), $urandom_range(65535), 131071);
            3: begin
               setup(256, 300, 60000);
               count = 60;
            end
            4: begin
               setup($urandom_range(3), $urandom_range(65535), $urandom_range(65536));
               // no register at this index
               write_reg(CSR_UNUSED, $urandom_range(131071));
               csr_wr_en <= 1'b0;
            end
            5: begin
               setup(511, $urandom_range(2000), 65536);
               count = 40;
            end
            6: begin
               setup($urandom_range(40, 4), $urandom_range(65535), $urandom_range(65536));
               calm = 1'b1;
            end
            default: setup($urandom_range(100, 4), $urandom_range(65535),
                           $urandom_range(131071));
         endcase
         send_beat(psw_pkg::OP_PLUCK, 17'($urandom_range(65536)), 24'($urandom()));
         repeat (count) send_random();
      end

      drain();
      $display("covered %0d plucks, %0d steps and %0d checked pickups over 9 register settings",
               book.plucks, book.steps, book.pickups);
      if (book.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// File: files.f
rtl/psw_pkg.sv
rtl/psw_req_if.sv
rtl/psw_rsp_if.sv
rtl/psw_ram.sv
rtl/plucked_string_wave_model.sv
test/tb_plucked_string_wave_model.sv
